// ===== hdl/bsrch_pkg.sv =====
// Shared types and constants for the bucketize binary search block.
// Depends on nothing; the level, top level and checker files import it.
`timescale 1ns / 1ps

package bsrch_pkg;

  localparam int unsigned MaxBoundaries = 256;
  localparam int unsigned IdxW = $clog2(MaxBoundaries);
  localparam int unsigned CntW = $clog2(MaxBoundaries + 1);
  localparam int unsigned NumLevels = $clog2(MaxBoundaries + 1);
  localparam int unsigned ValW = 64;

  typedef enum logic [0:0] {
    OpLoad     = 1'b0,
    OpClassify = 1'b1
  } op_e;

  typedef struct packed {
    logic                   valid;
    op_e                    op;
    logic [IdxW-1:0]        idx;
    logic signed [ValW-1:0] key;
    logic [CntW-1:0]        lo;
    logic [CntW-1:0]        hi;
  } item_t;

endpackage

// ===== hdl/bsrch_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bsrch_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hdl/bsrch_level.sv =====
// One search level: a private copy of the boundary table, a probe read stage
// and a compare stage. Depends on bsrch_pkg and bsrch_ram.
`timescale 1ns / 1ps

module bsrch_level (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  bsrch_pkg::item_t item_i,
  output bsrch_pkg::item_t item_o
);
  import bsrch_pkg::*;

  logic [CntW-1:0]  span;
  logic [IdxW-1:0]  mid_d;
  logic [IdxW-1:0]  mid_q;
  logic [ValW-1:0]  rdata;
  logic             wr_en;
  item_t            rd_q;
  item_t            item_d;
  item_t            item_q;

  // Loads write this copy as they pass, so reads here stay in item order.
  assign span  = item_i.hi - item_i.lo;
  assign mid_d = IdxW'(item_i.lo + (span >> 1));
  assign wr_en = en_i & item_i.valid & (item_i.op == OpLoad);

  bsrch_ram #(
    .Width(ValW),
    .Depth(MaxBoundaries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(item_i.idx),
    .wdata_i(item_i.key),
    .re_i   (en_i),
    .raddr_i(mid_d),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q.valid <= 1'b0;
    end else if (en_i) begin
      rd_q  <= item_i;
      mid_q <= mid_d;
    end
  end

  always_comb begin
    item_d = rd_q;
    if (rd_q.valid && (rd_q.op == OpClassify) && (rd_q.lo < rd_q.hi)) begin
      if ($signed(rd_q.key) <= $signed(rdata)) begin
        item_d.hi = CntW'(mid_q);
      end else begin
        item_d.lo = CntW'(mid_q) + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q.valid <= 1'b0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

// ===== hdl/bucketize_binary_search.sv =====
// Top level of the bucketize binary search: count register and a chain of
// search levels. Depends on bsrch_pkg and bsrch_level.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_stall_o    operation_i, boundary_index_i, value_i
// output    out        out_valid_o / out_stall_i  bucket_index_o
// config    in         cfg_we_i                   cfg_wdata_i
//
// One word enters per cycle while the pipeline is not stalled; a classify word
// leaves after a table read stage, then a compare stage, in each of 9 levels.
// Each level owns a copy of the table, written as a load word passes it.
// Reset clears the count register and all valid bits; the table is not cleared.
// When the output word is stalled the whole pipeline holds.

module bucketize_binary_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [bsrch_pkg::CntW-1:0]         cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic                               operation_i,
  input  logic [bsrch_pkg::IdxW-1:0]         boundary_index_i,
  input  logic signed [bsrch_pkg::ValW-1:0]  value_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [bsrch_pkg::CntW-1:0]         bucket_index_o
);
  import bsrch_pkg::*;

  logic [CntW-1:0] num_boundaries_q;
  logic [CntW-1:0] count;
  logic            en;
  item_t           chain [NumLevels+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_boundaries_q <= '0;
    end else if (cfg_we_i) begin
      num_boundaries_q <= cfg_wdata_i;
    end
  end

  assign count = (num_boundaries_q > CntW'(MaxBoundaries)) ? CntW'(MaxBoundaries)
                                                             : num_boundaries_q;

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_comb begin
    chain[0].valid = in_valid_i;
    chain[0].op    = op_e'(operation_i);
    chain[0].idx   = boundary_index_i;
    chain[0].key   = value_i;
    chain[0].lo    = '0;
    chain[0].hi    = count;
  end

  for (genvar g = 0; g < NumLevels; g++) begin : g_level
    bsrch_level u_level (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .item_i(chain[g]),
      .item_o(chain[g+1])
    );
  end

  assign out_valid_o    = chain[NumLevels].valid && (chain[NumLevels].op == OpClassify);
  assign bucket_index_o = chain[NumLevels].lo;

endmodule

// ===== hdl/bsrch_checker.sv =====
// Port-level checks for the bucketize binary search, bound to the top level.
// Depends on bsrch_pkg and bucketize_binary_search.
`timescale 1ns / 1ps

module bsrch_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_stall_o,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [bsrch_pkg::CntW-1:0]         bucket_index_o
);
  import bsrch_pkg::*;

  // The input side stalls exactly when a finished word is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(bucket_index_o))
    else $error("stalled output word changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> bucket_index_o <= CntW'(MaxBoundaries))
    else $error("bucket index beyond table capacity");

  // No word is valid at the output in the cycle after reset is sampled low.
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind bucketize_binary_search bsrch_checker u_bsrch_checker (.*);
